// File: rtl/u8v_pkg.sv
// Package for the UTF-8 stream validator: byte constants, continuation rule
// codes and the scan state record. No dependencies.
`default_nettype none

package u8v_pkg;

   // Lead byte ranges
   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;
   localparam logic [7:0] LEAD_SURR = 8'hED;

   // Continuation byte form and first-continuation limits
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] LIMIT_A0  = 8'hA0;
   localparam logic [7:0] LIMIT_90  = 8'h90;
   localparam logic [7:0] ASCII_TOP = 8'h80;

   // Limit placed on the next continuation byte
   typedef enum logic [2:0] {
      RULE_NONE     = 3'd0,
      RULE_MIN_A0   = 3'd1,
      RULE_BELOW_A0 = 3'd2,
      RULE_MIN_90   = 3'd3,
      RULE_BELOW_90 = 3'd4
   } u8v_rule_type;

   // Scan state carried from byte to byte
   typedef struct packed {
      logic [1:0]   pending;
      u8v_rule_type rule;
      logic         failed;
   } u8v_state_type;

   localparam u8v_state_type STATE_CLEAR = '{pending: 2'd0, rule: RULE_NONE, failed: 1'b0};

endpackage : u8v_pkg

`default_nettype wire

// File: rtl/u8v_check.sv
// Combinational byte check for the UTF-8 validator: next scan state and verdict
// for one transaction. Depends on u8v_pkg.
`default_nettype none

module u8v_check (
   input  wire logic [7:0]             data_byte,
   input  wire logic                   has_byte,
   input  wire logic                   end_of_string,
   input  wire u8v_pkg::u8v_state_type cur_state,
   output      u8v_pkg::u8v_state_type next_state,
   output      logic                   verdict
);
   import u8v_pkg::*;

   u8v_state_type scan;
   logic          cont_bad;

   // Limit check on a continuation byte
   always_comb begin
      cont_bad = ((data_byte & CONT_MASK) != CONT_TAG);
      case (cur_state.rule)
         RULE_MIN_A0:   cont_bad = cont_bad || (data_byte < LIMIT_A0);
         RULE_BELOW_A0: cont_bad = cont_bad || (data_byte >= LIMIT_A0);
         RULE_MIN_90:   cont_bad = cont_bad || (data_byte < LIMIT_90);
         RULE_BELOW_90: cont_bad = cont_bad || (data_byte >= LIMIT_90);
         default:       cont_bad = cont_bad;
      endcase
   end

   // State update for the byte, if any
   always_comb begin
      scan = cur_state;
      if (has_byte && !cur_state.failed) begin
         if (cur_state.pending == 2'd0) begin
            // lead byte
            if (data_byte == 8'h00) begin
               scan.failed = 1'b1;
            end else if (data_byte < ASCII_TOP) begin
               scan = cur_state;
            end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
               scan.pending = 2'd1;
               scan.rule    = RULE_NONE;
            end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
               scan.pending = 2'd2;
               if (data_byte == LEAD3_LO) begin
                  scan.rule = RULE_MIN_A0;
               end else if (data_byte == LEAD_SURR) begin
                  scan.rule = RULE_BELOW_A0;
               end else begin
                  scan.rule = RULE_NONE;
               end
            end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
               scan.pending = 2'd3;
               if (data_byte == LEAD4_LO) begin
                  scan.rule = RULE_MIN_90;
               end else if (data_byte == LEAD4_HI) begin
                  scan.rule = RULE_BELOW_90;
               end else begin
                  scan.rule = RULE_NONE;
               end
            end else begin
               scan.failed = 1'b1;
            end
         end else begin
            // continuation byte
            scan.rule = RULE_NONE;
            if (cont_bad) begin
               scan.failed = 1'b1;
            end else begin
               scan.pending = cur_state.pending - 2'd1;
            end
         end
      end
   end

   // Verdict and clear at end of string
   assign verdict    = !scan.failed && (scan.pending == 2'd0);
   assign next_state = end_of_string ? STATE_CLEAR : scan;

endmodule : u8v_check

`default_nettype wire

// File: rtl/utf8_stream_validator.sv
// Top level of the strict UTF-8 stream validator: input register, byte check,
// result register. Depends on u8v_pkg and u8v_check.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one transaction per byte:
//   req_data_byte, req_has_byte and req_end_of_string. A transaction with
//   req_has_byte low and req_end_of_string high closes an empty string (or
//   the bytes already sent); with both low it is an idle transaction.
//   Response channel (rsp_valid/rsp_ready) gives one rsp_string_valid per
//   closed string, in order.
//   Throughput: one transaction per cycle, sustained while no closing
//   transaction waits on rsp_ready. Each byte is checked by combinational logic
//   between the input register and the scan state. The verdict goes to the
//   result register, seen on rsp_valid, as the closing transaction moves on.
//   Stall: while a verdict waits on rsp_ready, bytes that do not close a
//   string keep flowing; a closing transaction waits in the input register,
//   and req_ready drops only when that register cannot move on.
//   Reset (synchronous, active high): empties both registers and clears
//   the scan state, so the next byte starts a new string.
`default_nettype none

module utf8_stream_validator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_end_of_string,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_string_valid
);
   import u8v_pkg::*;

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   logic          in_has_ff;
   logic          in_eos_ff;
   u8v_state_type state_ff;
   u8v_state_type state_in;
   logic          verdict_in;
   logic          out_valid_ff;
   logic          out_verdict_ff;
   logic          advance;

   // Input register moves on unless a verdict has nowhere to go
   assign advance   = in_valid_ff && (!in_eos_ff || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_data_byte;
         in_has_ff  <= req_has_byte;
         in_eos_ff  <= req_end_of_string;
      end
   end

   // Byte check
   u8v_check u_check (
      .data_byte     (in_byte_ff),
      .has_byte      (in_has_ff),
      .end_of_string (in_eos_ff),
      .cur_state     (state_ff),
      .next_state    (state_in),
      .verdict       (verdict_in)
   );

   // Scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= STATE_CLEAR;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_eos_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_eos_ff) begin
         out_verdict_ff <= verdict_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_string_valid = out_verdict_ff;

   // Checks
   a_clear_after_end: assert property (@(posedge clock) disable iff (reset)
      (advance && in_eos_ff) |=> (state_ff == STATE_CLEAR))
      else $error("scan state not cleared after end of string");

   a_rule_needs_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff.rule != RULE_NONE) |-> (state_ff.pending != 2'd0))
      else $error("continuation rule set with no continuation owed");

   a_fail_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff.failed && !(advance && in_eos_ff)) |=> state_ff.failed)
      else $error("failure flag dropped before end of string");

   a_rsp_from_end: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(advance && in_eos_ff))
      else $error("verdict raised without a closing transaction");

endmodule : utf8_stream_validator

`default_nettype wire

// File: dv/utf8_verdict_checker.sv
// Checker for the UTF-8 stream validator: watches both channels, predicts each
// string verdict from the accepted byte transactions and compares it in order.
// Depends on u8v_pkg for the byte constants, rule codes and scan state record.
`timescale 1ns / 100ps

module utf8_verdict_checker (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_has_byte,
   input  wire logic       req_end_of_string,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic       rsp_string_valid,
   output int              mismatch_count,
   output int              verdicts_owed,
   output int              verdicts_checked,
   output int              valid_verdicts
);
   import u8v_pkg::*;

   bit            expected_verdicts[$];
   u8v_state_type scan;
   bit            want;

   // Scan one byte of a string that has not failed yet
   function automatic u8v_state_type advance_scan(input u8v_state_type s,
                                                  input logic [7:0] c);
      u8v_state_type n;
      logic          bad;
      n = s;
      if (s.pending == 2'd0) begin
         // lead byte or plain ASCII
         if (c == 8'h00) begin
            n.failed = 1'b1;
         end else if (c >= ASCII_TOP) begin
            if (c >= LEAD2_LO && c <= LEAD2_HI) n.pending = 2'd1;
            else if (c >= LEAD3_LO && c <= LEAD3_HI) n.pending = 2'd2;
            else if (c >= LEAD4_LO && c <= LEAD4_HI) n.pending = 2'd3;
            else n.failed = 1'b1;
            if (!n.failed) begin
               case (c)
                  LEAD3_LO:  n.rule = RULE_MIN_A0;
                  LEAD_SURR: n.rule = RULE_BELOW_A0;
                  LEAD4_LO:  n.rule = RULE_MIN_90;
                  LEAD4_HI:  n.rule = RULE_BELOW_90;
                  default:   n.rule = RULE_NONE;
               endcase
            end
         end
      end else begin
         // continuation byte, first one possibly range-limited
         bad = (c & CONT_MASK) != CONT_TAG;
         case (s.rule)
            RULE_MIN_A0:   bad = bad || (c < LIMIT_A0);
            RULE_BELOW_A0: bad = bad || (c >= LIMIT_A0);
            RULE_MIN_90:   bad = bad || (c < LIMIT_90);
            RULE_BELOW_90: bad = bad || (c >= LIMIT_90);
            default:       ;
         endcase
         n.rule = RULE_NONE;
         if (bad) n.failed = 1'b1;
         else n.pending = s.pending - 2'd1;
      end
      return n;
   endfunction

   // Result side is checked before the request side; latency keeps them apart
   always @(posedge clock) begin
      if (reset) begin
         scan = STATE_CLEAR;
         expected_verdicts.delete();
         mismatch_count = 0;
         verdicts_owed = 0;
         verdicts_checked = 0;
         valid_verdicts = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               $display("%0t: unexpected verdict, expected none, actual %0b",
                        $time, rsp_string_valid);
               mismatch_count++;
            end else begin
               want = expected_verdicts.pop_front();
               verdicts_checked++;
               if (rsp_string_valid !== want) begin
                  $display("%0t: verdict mismatch, expected %0b, actual %0b",
                           $time, want, rsp_string_valid);
                  mismatch_count++;
               end
            end
            if (rsp_string_valid === 1'b1) valid_verdicts++;
         end
         if (req_valid && req_ready) begin
            if (req_has_byte && !scan.failed) scan = advance_scan(scan, req_data_byte);
            if (req_end_of_string) begin
               expected_verdicts.insert(expected_verdicts.size(),
                                        !scan.failed && scan.pending == 2'd0);
               scan = STATE_CLEAR;
            end
         end
         verdicts_owed = expected_verdicts.size();
      end
   end

endmodule

// File: dv/testbench.sv
// Top of the UTF-8 stream validator testbench: clock, reset, byte stimulus,
// result-side back-pressure and the verdict. Depends on utf8_stream_validator
// and utf8_verdict_checker.
`timescale 1ns / 100ps

module testbench;

   localparam int RANDOM_ITEMS = 1600;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 10;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_has_byte;
   logic       req_end_of_string;
   logic       rsp_valid;
   logic       rsp_ready;
   logic       rsp_string_valid;

   int mismatch_count;
   int verdicts_owed;
   int verdicts_checked;
   int valid_verdicts;

   int         send_idle_pct;
   int         recv_idle_pct;
   int         txn_count;
   int         idle_txn_count;
   int         string_count;
   int         cycle_count;
   logic [7:0] string_bytes[$];

   utf8_stream_validator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_string_valid  (rsp_string_valid)
   );

   utf8_verdict_checker verdict_check (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_string_valid  (rsp_string_valid),
      .mismatch_count    (mismatch_count),
      .verdicts_owed     (verdicts_owed),
      .verdicts_checked  (verdicts_checked),
      .valid_verdicts    (valid_verdicts)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("utf8_stream_validator verification failed");
      $finish;
   end

   // Result-side back-pressure
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   function automatic logic [7:0] rand_byte(input int lo, input int hi);
      return 8'($urandom_range(hi, lo));
   endfunction

   // Append one byte to the string under construction
   task automatic add_byte(input logic [7:0] b);
      string_bytes.insert(string_bytes.size(), b);
   endtask

   // One transaction: optional random gap, then hold until accepted
   task automatic send_txn(input logic [7:0] b, input logic has, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_has_byte      <= has;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      if (has || eos) txn_count++;
      else idle_txn_count++;
   endtask

   // Send string_bytes as one string, closed on the last byte or by a marker
   task automatic send_string(input bit close_by_marker, input bit add_idles);
      int i;
      for (i = 0; i < string_bytes.size(); i++) begin
         if (add_idles && $urandom_range(11) == 0) send_txn(rand_byte(0, 255), 1'b0, 1'b0);
         send_txn(string_bytes[i], 1'b1,
                  !close_by_marker && (i == string_bytes.size() - 1));
      end
      if (close_by_marker || string_bytes.size() == 0) send_txn(rand_byte(0, 255), 1'b0, 1'b1);
      string_count++;
   endtask

   // Append one well-formed code point of random length
   task automatic append_char();
      logic [7:0] lead;
      case ($urandom_range(3))
         0: add_byte(rand_byte(8'h01, 8'h7F));
         1: begin
            add_byte(rand_byte(8'hC2, 8'hDF));
            add_byte(rand_byte(8'h80, 8'hBF));
         end
         2: begin
            lead = rand_byte(8'hE0, 8'hEF);
            add_byte(lead);
            if (lead == 8'hE0) add_byte(rand_byte(8'hA0, 8'hBF));
            else if (lead == 8'hED) add_byte(rand_byte(8'h80, 8'h9F));
            else add_byte(rand_byte(8'h80, 8'hBF));
            add_byte(rand_byte(8'h80, 8'hBF));
         end
         default: begin
            lead = rand_byte(8'hF0, 8'hF4);
            add_byte(lead);
            if (lead == 8'hF0) add_byte(rand_byte(8'h90, 8'hBF));
            else if (lead == 8'hF4) add_byte(rand_byte(8'h80, 8'h8F));
            else add_byte(rand_byte(8'h80, 8'hBF));
            add_byte(rand_byte(8'h80, 8'hBF));
            add_byte(rand_byte(8'h80, 8'hBF));
         end
      endcase
   endtask

   // Mostly well-formed strings, some corrupted, truncated or pure noise
   task automatic send_random_string();
      int n, i;
      string_bytes.delete();
      if ($urandom_range(9) == 0) begin
         n = $urandom_range(6, 1);
         for (i = 0; i < n; i++) add_byte(rand_byte(0, 255));
      end else begin
         n = $urandom_range(6, 0);
         for (i = 0; i < n; i++) append_char();
         if (string_bytes.size() != 0 && $urandom_range(9) == 0)
            string_bytes[$urandom_range(string_bytes.size() - 1)] = rand_byte(0, 255);
         if (string_bytes.size() != 0 && $urandom_range(14) == 0)
            void'(string_bytes.pop_back());
      end
      send_string($urandom_range(3) == 0, 1'b1);
   endtask

   task automatic wait_drained();
      while (verdicts_owed != 0) @(negedge clock);
   endtask

   // Edge cases: empty string, zero byte, each lead class and its limits
   task automatic run_directed();
      send_txn(8'h41, 1'b0, 1'b1);                // empty string
      send_txn(8'h00, 1'b1, 1'b1);                // zero byte
      send_txn(8'h7F, 1'b1, 1'b0);                // ASCII top plus 2-byte max
      send_txn(8'hDF, 1'b1, 1'b0);
      send_txn(8'hBF, 1'b1, 1'b1);
      send_txn(8'hE0, 1'b1, 1'b0);                // smallest 3-byte form
      send_txn(8'hA0, 1'b1, 1'b0);
      send_txn(8'h80, 1'b1, 1'b1);
      send_txn(8'hE0, 1'b1, 1'b0);                // overlong 3-byte
      send_txn(8'h9F, 1'b1, 1'b1);
      send_txn(8'hED, 1'b1, 1'b0);                // surrogate, idle, marker close
      send_txn(8'hA0, 1'b1, 1'b0);
      send_txn(8'hFF, 1'b0, 1'b0);
      send_txn(8'h00, 1'b0, 1'b1);
      send_txn(8'hF4, 1'b1, 1'b0);                // U+10FFFF
      send_txn(8'h8F, 1'b1, 1'b0);
      send_txn(8'hBF, 1'b1, 1'b0);
      send_txn(8'hBF, 1'b1, 1'b1);
      send_txn(8'hF0, 1'b1, 1'b0);                // overlong 4-byte
      send_txn(8'h8F, 1'b1, 1'b1);
      send_txn(8'hC1, 1'b1, 1'b0);                // bad lead, later byte ignored
      send_txn(8'h41, 1'b1, 1'b1);
      send_txn(8'hE1, 1'b1, 1'b0);                // truncated sequence
      send_txn(8'h80, 1'b1, 1'b1);
      send_txn(8'h80, 1'b1, 1'b1);                // stray continuation
      string_count += 11;
   endtask

   // Stimulus and verdict
   initial begin : stimulus
      int phase;
      int directed_txns;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_data_byte     <= 8'h00;
      req_has_byte      <= 1'b0;
      req_end_of_string <= 1'b0;
      send_idle_pct     = 34;
      recv_idle_pct     = 49;
      txn_count         = 0;
      idle_txn_count    = 0;
      string_count      = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      run_directed();
      directed_txns = txn_count;
      req_valid <= 1'b0;
      wait_drained();

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 34; recv_idle_pct = 49; end
            1: begin send_idle_pct = 49; recv_idle_pct = 34; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         while (txn_count < directed_txns + (phase + 1) * RANDOM_ITEMS / 3)
            send_random_string();
         // hold off until every verdict of this phase is back
         req_valid <= 1'b0;
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Covered %0d strings in %0d byte/marker transactions and %0d idle ones,",
               string_count, txn_count, idle_txn_count);
      $display("under three back-pressure mixes; %0d verdicts checked, %0d of them valid.",
               verdicts_checked, valid_verdicts);
      if (mismatch_count == 0) begin
         $display("utf8_stream_validator verification clean");
      end else begin
         $display("utf8_stream_validator verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/u8v_pkg.sv
rtl/u8v_check.sv
rtl/utf8_stream_validator.sv
dv/utf8_verdict_checker.sv
dv/testbench.sv
